// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by positional_insert_delete_list_core
// no dependencies; define SYNTH to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/plidl_pkg.sv -----
// types and constants of the positional insert/delete list
// no dependencies
`timescale 1ns / 1ps

package plidl_pkg;

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 8;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_UPDATE,
    CMD_DELETE
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/positional_insert_delete_list_core.sv -----
// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of cells, one entry
// per cell; insert, update and delete act on all cells at once and clear resets only the
// count, so these transactions can be taken every cycle while the result is not stalled. A
// read gathers the addressed entry through a registered or-tree and waits out the depth of
// that tree. A finished result sits in an output register, so the next transaction is
// accepted while it waits. Entries need no clearing pass after reset.
// depends on plidl_pkg, plidl_cell, plidl_or_tree, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_insert_delete_list_core #(
  parameter int CAPACITY = 128
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [plidl_pkg::OP_W-1:0]            op,
  input  logic [plidl_pkg::POS_W-1:0]           position,
  input  logic signed [plidl_pkg::VALUE_W-1:0]  value,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [plidl_pkg::STATUS_W-1:0]        status,
  output logic signed [plidl_pkg::VALUE_W-1:0]  read_value,
  output logic [plidl_pkg::LEN_W-1:0]           length
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = $clog2(CAPACITY);
  localparam int WAIT_W = $clog2(LEVELS + 1);
  localparam int CW     = (CNT_W > plidl_pkg::POS_W) ? CNT_W : plidl_pkg::POS_W;

  typedef enum logic {
    S_IDLE,
    S_HELD
  } state_t;

  state_t                         state;
  logic [plidl_pkg::OP_W-1:0]     op_q;
  logic [plidl_pkg::POS_W-1:0]    pos_q;
  logic [plidl_pkg::VALUE_W-1:0]  value_q;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               count_next;
  logic [WAIT_W-1:0]              wait_cnt;

  plidl_pkg::status_t             st;
  plidl_pkg::cell_ctrl_t          ctrl;
  logic                           done_now;
  logic                           is_read;
  logic                           accept;
  logic [CW-1:0]                  pos_c;
  logic [CW-1:0]                  cnt_c;
  logic [plidl_pkg::VALUE_W-1:0]  root;

  logic [plidl_pkg::VALUE_W-1:0]  cell_data [CAPACITY];
  logic [plidl_pkg::VALUE_W-1:0]  cell_leaf [CAPACITY];

  assign pos_c   = CW'(pos_q);
  assign cnt_c   = CW'(count);
  assign is_read = (op_q == plidl_pkg::OP_READ);

  always_comb begin
    st         = plidl_pkg::ST_OK;
    count_next = count;
    case (op_q)
      plidl_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      plidl_pkg::OP_INSERT: begin
        if (pos_c > cnt_c) begin
          st = plidl_pkg::ST_RANGE;
        end else if (count == CNT_W'(CAPACITY)) begin
          st = plidl_pkg::ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      plidl_pkg::OP_UPDATE, plidl_pkg::OP_READ: begin
        if (pos_c >= cnt_c) begin
          st = plidl_pkg::ST_RANGE;
        end
      end
      plidl_pkg::OP_DELETE: begin
        if (pos_c >= cnt_c) begin
          st = plidl_pkg::ST_RANGE;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign done_now = (state == S_HELD)
                 && (!is_read || (wait_cnt == WAIT_W'(LEVELS)))
                 && (!result_valid || !result_stall);
  assign item_stall = rst || ((state == S_HELD) && !done_now);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    ctrl.cmd   = plidl_pkg::CMD_HOLD;
    ctrl.pos   = pos_q;
    ctrl.value = value_q;
    if (done_now && (st == plidl_pkg::ST_OK)) begin
      case (op_q)
        plidl_pkg::OP_INSERT: ctrl.cmd = plidl_pkg::CMD_INSERT;
        plidl_pkg::OP_UPDATE: ctrl.cmd = plidl_pkg::CMD_UPDATE;
        plidl_pkg::OP_DELETE: ctrl.cmd = plidl_pkg::CMD_DELETE;
        default:              ctrl.cmd = plidl_pkg::CMD_HOLD;
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [plidl_pkg::VALUE_W-1:0] left_d;
      logic [plidl_pkg::VALUE_W-1:0] right_d;
      if (i == 0) begin : g_first
        assign left_d = value_q;
      end else begin : g_left
        assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_d = cell_data[i];
      end else begin : g_right
        assign right_d = cell_data[i+1];
      end
      plidl_cell #(
        .INDEX (i),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[i]),
        .leaf       (cell_leaf[i])
      );
    end
  endgenerate

  plidl_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_leaf),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      wait_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (done_now) begin
        result_valid <= 1'b1;
        status       <= st;
        read_value   <= (is_read && (st == plidl_pkg::ST_OK)) ? root : '0;
        length       <= plidl_pkg::LEN_W'(count_next);
        count        <= count_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (accept) begin
        state    <= S_HELD;
        op_q     <= op;
        pos_q    <= position;
        value_q  <= value;
        wait_cnt <= '0;
      end else if (done_now) begin
        state <= S_IDLE;
      end else if ((state == S_HELD) && is_read && (wait_cnt != WAIT_W'(LEVELS))) begin
        wait_cnt <= wait_cnt + WAIT_W'(1);
      end
    end
  end

  `ASSERT_HOLDS(a_count_cap, clk, rst, count <= CNT_W'(CAPACITY), "count above capacity")
  `ASSERT_NEXT(a_insert_grows, clk, rst, done_now && (op_q == plidl_pkg::OP_INSERT) && (st == plidl_pkg::ST_OK), count == $past(count) + CNT_W'(1), "insert did not grow list")
  `ASSERT_NEXT(a_delete_shrinks, clk, rst, done_now && (op_q == plidl_pkg::OP_DELETE) && (st == plidl_pkg::ST_OK), count == $past(count) - CNT_W'(1), "delete did not shrink list")

endmodule

// ----- hw/rtl/plidl_cell.sv -----
// one list entry of the cell chain: shifts up, shifts down or loads
// depends on plidl_pkg
`timescale 1ns / 1ps

module plidl_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 7
) (
  input  logic                          clk,
  input  plidl_pkg::cell_ctrl_t         ctrl,
  input  logic [plidl_pkg::VALUE_W-1:0] left_data,
  input  logic [plidl_pkg::VALUE_W-1:0] right_data,
  output logic [plidl_pkg::VALUE_W-1:0] data,
  output logic [plidl_pkg::VALUE_W-1:0] leaf
);

  localparam int CW = (IDX_W > plidl_pkg::POS_W) ? IDX_W : plidl_pkg::POS_W;
  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

  logic [CW-1:0] pos_c;
  logic          hit;
  logic          above;

  assign pos_c = CW'(ctrl.pos);
  assign hit   = (pos_c == MY_IDX);
  assign above = (MY_IDX > pos_c);
  assign leaf  = hit ? data : '0;

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      plidl_pkg::CMD_INSERT: begin
        if (above) begin
          data <= left_data;
        end else if (hit) begin
          data <= ctrl.value;
        end
      end
      plidl_pkg::CMD_UPDATE: begin
        if (hit) begin
          data <= ctrl.value;
        end
      end
      plidl_pkg::CMD_DELETE: begin
        if (above || hit) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/plidl_or_tree.sv -----
// registered or-reduction tree that gathers the selected cell entry
// depends on plidl_pkg
`timescale 1ns / 1ps

module plidl_or_tree #(
  parameter int N = 128
) (
  input  logic                          clk,
  input  logic [plidl_pkg::VALUE_W-1:0] leaf [N],
  output logic [plidl_pkg::VALUE_W-1:0] root
);

  localparam int LEVELS = $clog2(N);
  localparam int P      = 1 << LEVELS;

  logic [plidl_pkg::VALUE_W-1:0] node [1:P-1];

  genvar k;
  generate
    for (k = 1; k < P; k++) begin : g_node
      if (2 * k >= P) begin : g_bottom
        localparam int LI = 2 * k - P;
        localparam int RI = 2 * k + 1 - P;
        logic [plidl_pkg::VALUE_W-1:0] lv;
        logic [plidl_pkg::VALUE_W-1:0] rv;
        if (LI < N) begin : g_l
          assign lv = leaf[LI];
        end else begin : g_lz
          assign lv = '0;
        end
        if (RI < N) begin : g_r
          assign rv = leaf[RI];
        end else begin : g_rz
          assign rv = '0;
        end
        always_ff @(posedge clk) begin
          node[k] <= lv | rv;
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          node[k] <= node[2 * k] | node[2 * k + 1];
        end
      end
    end
  endgenerate

  assign root = node[1];

endmodule
